[rtl/si_pkg.sv]
// Shared types and constants for the segment intersection block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package si_pkg;

    // Width of the fixed-point result fields.
    localparam int RES_BITS = 32;

    // Which rule decides the hit for a request.
    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_VERTICAL = 2'd1,
        MODE_GENERAL  = 2'd2
    } si_mode_t;

    // Control flags that travel with a request from the setup pipeline into the divider.
    typedef struct packed {
        logic hit;
        logic neg_x;
        logic neg_y;
    } si_flags_t;

endpackage

`default_nettype wire

[rtl/si_ifs.sv]
// Valid/ready channel interfaces for the segment intersection block.
// Depends on si_pkg for the result width.
`default_nettype none

interface si_req_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
        output second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
        input  second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

interface si_res_if ();
    import si_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic signed [RES_BITS-1:0] cross_x;
    logic signed [RES_BITS-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

`default_nettype wire

[rtl/si_setup.sv]
// Six-stage front end: cross products, hit tests and the numerators and divisor for the divider.
// Depends on si_pkg for the mode codes and the flag struct.
`default_nettype none

module si_setup #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_BITS-1:0]   first_start_x,
    input  logic signed [COORD_BITS-1:0]   first_start_y,
    input  logic signed [COORD_BITS-1:0]   first_end_x,
    input  logic signed [COORD_BITS-1:0]   first_end_y,
    input  logic signed [COORD_BITS-1:0]   second_start_x,
    input  logic signed [COORD_BITS-1:0]   second_start_y,
    input  logic signed [COORD_BITS-1:0]   second_end_x,
    input  logic signed [COORD_BITS-1:0]   second_end_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output si_pkg::si_flags_t              out_flags,
    output logic [3*COORD_BITS+4:0]        num_x_mag,
    output logic [3*COORD_BITS+4:0]        num_y_mag,
    output logic [2*COORD_BITS+2:0]        div_mag
);
    import si_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;          // coordinate differences
    localparam int PW = 2 * DW;         // products of two differences
    localparam int KW = 2 * C + 3;      // cross products
    localparam int MW = C + KW;         // coordinate times cross product
    localparam int RW = DW + KW;        // difference times cross product
    localparam int VW = C + DW;         // coordinate times difference
    localparam int NW = 3 * C + 5;      // numerators
    localparam int NS = 6;

    // Stage valid bits and the ready chain; a stage loads when it is empty or its successor moves.
    logic [NS-1:0] vld_reg;
    logic [NS:0]   take;

    assign take[NS] = out_ready;
    for (genvar i = 0; i < NS; i++) begin : g_take
        assign take[i] = !vld_reg[i] || take[i+1];
    end
    assign in_ready  = take[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (take[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (take[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1: classify the pair, differences, and the roles of the vertical case.
    logic                  vert1, vert2, span_next;
    si_mode_t              mode_next;
    logic signed [C-1:0]   vx, va, vb, ax, ay, bx, by, vmin_next, vmax_next;

    always_comb
    begin
        vert1 = first_start_x == first_end_x;
        vert2 = second_start_x == second_end_x;
        if (vert1 && vert2)
        begin
            mode_next = MODE_NONE;
        end
        else if (vert1 || vert2)
        begin
            mode_next = MODE_VERTICAL;
        end
        else
        begin
            mode_next = MODE_GENERAL;
        end
        vx = vert1 ? first_start_x : second_start_x;
        va = vert1 ? first_start_y : second_start_y;
        vb = vert1 ? first_end_y : second_end_y;
        ax = vert1 ? second_start_x : first_start_x;
        ay = vert1 ? second_start_y : first_start_y;
        bx = vert1 ? second_end_x : first_end_x;
        by = vert1 ? second_end_y : first_end_y;
        span_next = (vx >= ax || vx >= bx) && (vx <= ax || vx <= bx);
        vmin_next = (va < vb) ? va : vb;
        vmax_next = (va < vb) ? vb : va;
    end

    si_mode_t             s1_mode_reg;
    logic                 s1_span_reg;
    logic signed [DW-1:0] s1_rx_reg, s1_ry_reg, s1_sx_reg, s1_sy_reg, s1_wx_reg, s1_wy_reg;
    logic signed [DW-1:0] s1_oden_reg, s1_ody_reg, s1_odx_reg;
    logic signed [C-1:0]  s1_x1_reg, s1_y1_reg, s1_vx_reg, s1_vmin_reg, s1_vmax_reg, s1_ay_reg;

    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            s1_mode_reg <= mode_next;
            s1_span_reg <= span_next;
            s1_rx_reg   <= DW'(first_end_x) - DW'(first_start_x);
            s1_ry_reg   <= DW'(first_end_y) - DW'(first_start_y);
            s1_sx_reg   <= DW'(second_end_x) - DW'(second_start_x);
            s1_sy_reg   <= DW'(second_end_y) - DW'(second_start_y);
            s1_wx_reg   <= DW'(second_start_x) - DW'(first_start_x);
            s1_wy_reg   <= DW'(second_start_y) - DW'(first_start_y);
            s1_oden_reg <= DW'(bx) - DW'(ax);
            s1_ody_reg  <= DW'(by) - DW'(ay);
            s1_odx_reg  <= DW'(vx) - DW'(ax);
            s1_x1_reg   <= first_start_x;
            s1_y1_reg   <= first_start_y;
            s1_vx_reg   <= vx;
            s1_vmin_reg <= vmin_next;
            s1_vmax_reg <= vmax_next;
            s1_ay_reg   <= ay;
        end
    end

    // Stage 2: the partial products of the three cross products and the vertical numerator.
    si_mode_t             s2_mode_reg;
    logic                 s2_span_reg;
    logic signed [PW-1:0] s2_pd1_reg, s2_pd2_reg, s2_pt1_reg, s2_pt2_reg, s2_pu1_reg, s2_pu2_reg;
    logic signed [PW-1:0] s2_pn1_reg, s2_pn2_reg;
    logic signed [DW-1:0] s2_rx_reg, s2_ry_reg, s2_oden_reg;
    logic signed [C-1:0]  s2_x1_reg, s2_y1_reg, s2_vx_reg, s2_vmin_reg, s2_vmax_reg;

    always_ff @(posedge clk)
    begin
        if (take[1])
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_span_reg <= s1_span_reg;
            s2_pd1_reg  <= PW'(s1_rx_reg) * PW'(s1_sy_reg);
            s2_pd2_reg  <= PW'(s1_ry_reg) * PW'(s1_sx_reg);
            s2_pt1_reg  <= PW'(s1_wx_reg) * PW'(s1_sy_reg);
            s2_pt2_reg  <= PW'(s1_wy_reg) * PW'(s1_sx_reg);
            s2_pu1_reg  <= PW'(s1_wx_reg) * PW'(s1_ry_reg);
            s2_pu2_reg  <= PW'(s1_wy_reg) * PW'(s1_rx_reg);
            s2_pn1_reg  <= PW'(s1_ay_reg) * PW'(s1_oden_reg);
            s2_pn2_reg  <= PW'(s1_ody_reg) * PW'(s1_odx_reg);
            s2_rx_reg   <= s1_rx_reg;
            s2_ry_reg   <= s1_ry_reg;
            s2_oden_reg <= s1_oden_reg;
            s2_x1_reg   <= s1_x1_reg;
            s2_y1_reg   <= s1_y1_reg;
            s2_vx_reg   <= s1_vx_reg;
            s2_vmin_reg <= s1_vmin_reg;
            s2_vmax_reg <= s1_vmax_reg;
        end
    end

    // Stage 3: combine the partial products.
    si_mode_t             s3_mode_reg;
    logic                 s3_span_reg;
    logic signed [KW-1:0] s3_d_reg, s3_tn_reg, s3_un_reg, s3_num_reg;
    logic signed [DW-1:0] s3_rx_reg, s3_ry_reg, s3_oden_reg;
    logic signed [C-1:0]  s3_x1_reg, s3_y1_reg, s3_vx_reg, s3_vmin_reg, s3_vmax_reg;

    always_ff @(posedge clk)
    begin
        if (take[2])
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_span_reg <= s2_span_reg;
            s3_d_reg    <= KW'(s2_pd1_reg) - KW'(s2_pd2_reg);
            s3_tn_reg   <= KW'(s2_pt1_reg) - KW'(s2_pt2_reg);
            s3_un_reg   <= KW'(s2_pu1_reg) - KW'(s2_pu2_reg);
            s3_num_reg  <= KW'(s2_pn1_reg) + KW'(s2_pn2_reg);
            s3_rx_reg   <= s2_rx_reg;
            s3_ry_reg   <= s2_ry_reg;
            s3_oden_reg <= s2_oden_reg;
            s3_x1_reg   <= s2_x1_reg;
            s3_y1_reg   <= s2_y1_reg;
            s3_vx_reg   <= s2_vx_reg;
            s3_vmin_reg <= s2_vmin_reg;
            s3_vmax_reg <= s2_vmax_reg;
        end
    end

    // Stage 4: parameter range test of the general case and the numerator products.
    // Signs are left unnormalised: the test flips with the sign of d.
    logic gen_ok_next;

    always_comb
    begin
        if (!s3_d_reg[KW-1])
        begin
            gen_ok_next = s3_tn_reg >= 0 && s3_tn_reg <= s3_d_reg &&
                          s3_un_reg >= 0 && s3_un_reg <= s3_d_reg;
        end
        else
        begin
            gen_ok_next = s3_tn_reg <= 0 && s3_tn_reg >= s3_d_reg &&
                          s3_un_reg <= 0 && s3_un_reg >= s3_d_reg;
        end
        gen_ok_next = gen_ok_next && (s3_d_reg != 0);
    end

    si_mode_t             s4_mode_reg;
    logic                 s4_span_reg, s4_gen_ok_reg;
    logic signed [MW-1:0] s4_x1d_reg, s4_y1d_reg;
    logic signed [RW-1:0] s4_rxtn_reg, s4_rytn_reg;
    logic signed [VW-1:0] s4_vlo_reg, s4_vhi_reg, s4_vxd_reg;
    logic signed [KW-1:0] s4_d_reg, s4_num_reg;
    logic signed [DW-1:0] s4_oden_reg;

    always_ff @(posedge clk)
    begin
        if (take[3])
        begin
            s4_mode_reg   <= s3_mode_reg;
            s4_span_reg   <= s3_span_reg;
            s4_gen_ok_reg <= gen_ok_next;
            s4_x1d_reg    <= MW'(s3_x1_reg) * MW'(s3_d_reg);
            s4_y1d_reg    <= MW'(s3_y1_reg) * MW'(s3_d_reg);
            s4_rxtn_reg   <= RW'(s3_rx_reg) * RW'(s3_tn_reg);
            s4_rytn_reg   <= RW'(s3_ry_reg) * RW'(s3_tn_reg);
            s4_vlo_reg    <= VW'(s3_vmin_reg) * VW'(s3_oden_reg);
            s4_vhi_reg    <= VW'(s3_vmax_reg) * VW'(s3_oden_reg);
            s4_vxd_reg    <= VW'(s3_vx_reg) * VW'(s3_oden_reg);
            s4_d_reg      <= s3_d_reg;
            s4_num_reg    <= s3_num_reg;
            s4_oden_reg   <= s3_oden_reg;
        end
    end

    // Stage 5: numerator sums, the open y range test and the choice between the two rules.
    // The vertical x is carried as vx * den so that both rules share one division.
    logic                 vert_ok, hit_next;
    logic signed [NW-1:0] nx, ny, numx_next, numy_next;
    logic signed [KW-1:0] div_next;

    always_comb
    begin
        nx = NW'(s4_x1d_reg) + NW'(s4_rxtn_reg);
        ny = NW'(s4_y1d_reg) + NW'(s4_rytn_reg);
        if (!s4_oden_reg[DW-1])
        begin
            vert_ok = s4_num_reg > KW'(s4_vlo_reg) && s4_num_reg < KW'(s4_vhi_reg);
        end
        else
        begin
            vert_ok = s4_num_reg < KW'(s4_vlo_reg) && s4_num_reg > KW'(s4_vhi_reg);
        end
        case (s4_mode_reg)
            MODE_GENERAL:
            begin
                hit_next  = s4_gen_ok_reg;
                numx_next = nx;
                numy_next = ny;
                div_next  = s4_d_reg;
            end
            MODE_VERTICAL:
            begin
                hit_next  = s4_span_reg && vert_ok;
                numx_next = NW'(s4_vxd_reg);
                numy_next = NW'(s4_num_reg);
                div_next  = KW'(s4_oden_reg);
            end
            default:
            begin
                hit_next  = 1'b0;
                numx_next = nx;
                numy_next = ny;
                div_next  = s4_d_reg;
            end
        endcase
    end

    logic                 s5_hit_reg;
    logic signed [NW-1:0] s5_numx_reg, s5_numy_reg;
    logic signed [KW-1:0] s5_div_reg;

    always_ff @(posedge clk)
    begin
        if (take[4])
        begin
            s5_hit_reg  <= hit_next;
            s5_numx_reg <= numx_next;
            s5_numy_reg <= numy_next;
            s5_div_reg  <= div_next;
        end
    end

    // Stage 6: magnitudes and quotient signs for the unsigned divider.
    si_flags_t     s6_flags_reg;
    logic [NW-1:0] s6_mx_reg, s6_my_reg;
    logic [KW-1:0] s6_div_reg;

    always_ff @(posedge clk)
    begin
        if (take[5])
        begin
            s6_flags_reg.hit   <= s5_hit_reg;
            s6_flags_reg.neg_x <= s5_numx_reg[NW-1] ^ s5_div_reg[KW-1];
            s6_flags_reg.neg_y <= s5_numy_reg[NW-1] ^ s5_div_reg[KW-1];
            s6_mx_reg  <= s5_numx_reg[NW-1] ? unsigned'(-s5_numx_reg) : unsigned'(s5_numx_reg);
            s6_my_reg  <= s5_numy_reg[NW-1] ? unsigned'(-s5_numy_reg) : unsigned'(s5_numy_reg);
            s6_div_reg <= s5_div_reg[KW-1] ? unsigned'(-s5_div_reg) : unsigned'(s5_div_reg);
        end
    end

    assign out_flags = s6_flags_reg;
    assign num_x_mag = s6_mx_reg;
    assign num_y_mag = s6_my_reg;
    assign div_mag   = s6_div_reg;

endmodule

`default_nettype wire

[rtl/si_divide.sv]
// Pipelined restoring divider: one quotient bit per stage for x and y over a shared divisor,
// then sign, truncation to the result width and the output register. Depends on si_pkg.
`default_nettype none

module si_divide #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  si_pkg::si_flags_t                   in_flags,
    input  logic [3*COORD_BITS+4:0]             num_x_mag,
    input  logic [3*COORD_BITS+4:0]             num_y_mag,
    input  logic [2*COORD_BITS+2:0]             div_mag,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic signed [si_pkg::RES_BITS-1:0]  cross_x,
    output logic signed [si_pkg::RES_BITS-1:0]  cross_y
);
    import si_pkg::*;

    localparam int KW = 2 * COORD_BITS + 3;
    localparam int NW = 3 * COORD_BITS + 5;
    localparam int QB = COORD_BITS + FRAC_BITS;   // quotient bits; a hit never needs more
    localparam int DV = NW + FRAC_BITS;
    localparam int NS = QB + 1;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   take;

    // Ready chain over the divide stages and the output register.
    assign take[NS] = out_ready;
    for (genvar i = 0; i < NS; i++) begin : g_take
        assign take[i] = !vld_reg[i] || take[i+1];
    end
    assign in_ready  = take[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (take[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (take[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Dividends scaled by the fractional bits. The part above the quotient bits seeds the
    // remainder; it is below the divisor whenever the request hits.
    logic [DV-1:0] dvd_x, dvd_y;
    assign dvd_x = {num_x_mag, {FRAC_BITS{1'b0}}};
    assign dvd_y = {num_y_mag, {FRAC_BITS{1'b0}}};

    logic [KW-1:0] rem_x_reg [QB];
    logic [KW-1:0] rem_y_reg [QB];
    logic [KW-1:0] div_reg   [QB];
    logic [QB-1:0] q_x_reg   [QB];
    logic [QB-1:0] q_y_reg   [QB];
    logic [QB-1:0] lo_x_reg  [QB];
    logic [QB-1:0] lo_y_reg  [QB];
    si_flags_t     flags_reg [QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [KW-1:0] rem_x_in, rem_y_in, div_in;
        logic [QB-1:0] q_x_in, q_y_in, lo_x_in, lo_y_in;
        si_flags_t     flags_in;
        logic [KW:0]   sh_x, sh_y;
        logic [KW+1:0] tr_x, tr_y;

        if (k == 0) begin : g_src
            assign rem_x_in = dvd_x[QB+KW-1:QB];
            assign rem_y_in = dvd_y[QB+KW-1:QB];
            assign div_in   = div_mag;
            assign q_x_in   = '0;
            assign q_y_in   = '0;
            assign lo_x_in  = dvd_x[QB-1:0];
            assign lo_y_in  = dvd_y[QB-1:0];
            assign flags_in = in_flags;
        end else begin : g_src
            assign rem_x_in = rem_x_reg[k-1];
            assign rem_y_in = rem_y_reg[k-1];
            assign div_in   = div_reg[k-1];
            assign q_x_in   = q_x_reg[k-1];
            assign q_y_in   = q_y_reg[k-1];
            assign lo_x_in  = lo_x_reg[k-1];
            assign lo_y_in  = lo_y_reg[k-1];
            assign flags_in = flags_reg[k-1];
        end

        // Shift in the next dividend bit and try the subtraction; no borrow gives a one.
        assign sh_x = {rem_x_in, lo_x_in[QB-1]};
        assign sh_y = {rem_y_in, lo_y_in[QB-1]};
        assign tr_x = {1'b0, sh_x} - {2'b00, div_in};
        assign tr_y = {1'b0, sh_y} - {2'b00, div_in};

        always_ff @(posedge clk)
        begin
            if (take[k])
            begin
                rem_x_reg[k] <= tr_x[KW+1] ? sh_x[KW-1:0] : tr_x[KW-1:0];
                rem_y_reg[k] <= tr_y[KW+1] ? sh_y[KW-1:0] : tr_y[KW-1:0];
                q_x_reg[k]   <= {q_x_in[QB-2:0], !tr_x[KW+1]};
                q_y_reg[k]   <= {q_y_in[QB-2:0], !tr_y[KW+1]};
                lo_x_reg[k]  <= {lo_x_in[QB-2:0], 1'b0};
                lo_y_reg[k]  <= {lo_y_in[QB-2:0], 1'b0};
                div_reg[k]   <= div_in;
                flags_reg[k] <= flags_in;
            end
        end
    end

    // Output stage: apply the sign, keep the low result bits, zero everything on a miss.
    logic signed [QB:0]         sq_x, sq_y;
    logic                       hit_reg;
    logic signed [RES_BITS-1:0] cross_x_reg, cross_y_reg;

    assign sq_x = flags_reg[QB-1].neg_x ? -$signed({1'b0, q_x_reg[QB-1]})
                                        : $signed({1'b0, q_x_reg[QB-1]});
    assign sq_y = flags_reg[QB-1].neg_y ? -$signed({1'b0, q_y_reg[QB-1]})
                                        : $signed({1'b0, q_y_reg[QB-1]});

    always_ff @(posedge clk)
    begin
        if (take[QB])
        begin
            hit_reg     <= flags_reg[QB-1].hit;
            cross_x_reg <= flags_reg[QB-1].hit ? RES_BITS'(sq_x) : '0;
            cross_y_reg <= flags_reg[QB-1].hit ? RES_BITS'(sq_y) : '0;
        end
    end

    assign hit     = hit_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;

endmodule

`default_nettype wire

[rtl/segment_intersection_top.sv]
// Top level of the segment intersection block: setup pipeline followed by the divider.
// Depends on si_pkg, si_ifs, si_setup and si_divide.
//
//   channel | role   | payload
//   --------+--------+-----------------------------------------------------------
//   req     | sink   | two segments, eight signed COORD_BITS endpoint coordinates
//   res     | source | hit, cross_x and cross_y in Q(32-FRAC_BITS).FRAC_BITS
//
// One request may enter every cycle unless a stall holds the pipeline. A request
// passes six setup stages, one divider stage per quotient bit and the output
// register. There is no state between requests and reset only clears the stage
// valid bits. Each stage holds while its successor is full and stalled, so empty
// stages still take requests while a result waits to be taken.
`default_nettype none

module segment_intersection_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    si_req_if.sink   req,
    si_res_if.source res
);
    import si_pkg::*;

    localparam int KW = 2 * COORD_BITS + 3;
    localparam int NW = 3 * COORD_BITS + 5;

    logic          mid_valid, mid_ready;
    si_flags_t     mid_flags;
    logic [NW-1:0] mid_num_x, mid_num_y;
    logic [KW-1:0] mid_div;

    // Cross products, hit decision and division operands.
    si_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (req.valid),
        .in_ready       (req.ready),
        .first_start_x  (req.first_start_x),
        .first_start_y  (req.first_start_y),
        .first_end_x    (req.first_end_x),
        .first_end_y    (req.first_end_y),
        .second_start_x (req.second_start_x),
        .second_start_y (req.second_start_y),
        .second_end_x   (req.second_end_x),
        .second_end_y   (req.second_end_y),
        .out_valid      (mid_valid),
        .out_ready      (mid_ready),
        .out_flags      (mid_flags),
        .num_x_mag      (mid_num_x),
        .num_y_mag      (mid_num_y),
        .div_mag        (mid_div)
    );

    // Fixed-point quotients and the output register.
    si_divide #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_flags  (mid_flags),
        .num_x_mag (mid_num_x),
        .num_y_mag (mid_num_y),
        .div_mag   (mid_div),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .hit       (res.hit),
        .cross_x   (res.cross_x),
        .cross_y   (res.cross_y)
    );

endmodule

`default_nettype wire
